// File: src/rotation_matrix_to_euler_angles_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotation matrix to Euler angles core.
// Shared helpers for the concurrent checks of the top level.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_CORE_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RME_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every clock edge outside reset.
`define RME_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// Constants and types shared by the rotation matrix to Euler angles core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rme_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned ZW = 20;   // angle accumulator, 2^-16 rad
  localparam int unsigned VW = 26;   // CORDIC working vector width
  localparam int unsigned SW = 31;   // square root remainder width, holds 2^30

  localparam logic signed [15:0] OneQ14     = 16'sd16384;
  localparam logic signed [ZW-1:0] HalfPiZ  = 20'sd102944;
  localparam logic signed [15:0] PiQ13      = 16'sd25736;
  localparam logic signed [15:0] HalfPiQ13  = 16'sd12868;

  // Arctangent table in units of 2^-16 rad.
  function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      4'd0:  v = 20'sd51472;
      4'd1:  v = 20'sd30386;
      4'd2:  v = 20'sd16055;
      4'd3:  v = 20'sd8150;
      4'd4:  v = 20'sd4091;
      4'd5:  v = 20'sd2047;
      4'd6:  v = 20'sd1024;
      4'd7:  v = 20'sd512;
      4'd8:  v = 20'sd256;
      4'd9:  v = 20'sd128;
      4'd10: v = 20'sd64;
      4'd11: v = 20'sd32;
      4'd12: v = 20'sd16;
      4'd13: v = 20'sd8;
      4'd14: v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

  // Vectoring CORDIC state carried between pipeline stages.
  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // Restoring square root state.
  typedef struct packed {
    logic [SW-1:0] rem;
    logic [SW-1:0] res;
  } sqrt_t;

  // Side information that follows each transaction through the pipeline.
  typedef struct packed {
    logic lock_pos;
    logic lock_neg;
  } side_t;

endpackage

// File: src/rme_cordic.sv
// ----------------------------------------------------------------------------
// rme_cordic
// Pipelined atan2 by vectoring CORDIC, one iteration per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rme_cordic (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [15:0]     y_i,
  input  logic signed [15:0]     x_i,
  output logic signed [15:0]     ang_o
);
  import rme_pkg::*;

  cordic_t stage_q [CordicSteps+1];
  cordic_t init_d;
  logic    zero_q [CordicSteps+1];
  logic signed [VW-1:0] xs, ys;
  logic signed [ZW-1:0] zr;

  // Prescale and fold the left half plane into the right.
  always_comb begin
    xs = VW'(x_i) <<< 8;
    ys = VW'(y_i) <<< 8;
    init_d.x = xs;
    init_d.y = ys;
    init_d.z = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        init_d.x = ys;
        init_d.y = -xs;
        init_d.z = HalfPiZ;
      end else begin
        init_d.x = -ys;
        init_d.y = xs;
        init_d.z = -HalfPiZ;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= init_d;
      zero_q[0]  <= (x_i == 16'sd0) && (y_i == 16'sd0);
    end
  end

  // One micro-rotation per register stage.
  for (genvar i = 0; i < CordicSteps; i++) begin : g_iter
    cordic_t nx;
    always_comb begin
      nx = stage_q[i];
      if (stage_q[i].y >= 0) begin
        nx.x = stage_q[i].x + (stage_q[i].y >>> i);
        nx.y = stage_q[i].y - (stage_q[i].x >>> i);
        nx.z = stage_q[i].z + atan_lut(4'(i));
      end else begin
        nx.x = stage_q[i].x - (stage_q[i].y >>> i);
        nx.y = stage_q[i].y + (stage_q[i].x >>> i);
        nx.z = stage_q[i].z - atan_lut(4'(i));
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[i+1] <= nx;
        zero_q[i+1]  <= zero_q[i];
      end
    end
  end

  // Round to Q3.13 and saturate to plus or minus pi.
  always_comb begin
    zr = (stage_q[CordicSteps].z + ZW'(4)) >>> 3;
    if (zero_q[CordicSteps])       ang_o = '0;
    else if (zr > ZW'(PiQ13))      ang_o = PiQ13;
    else if (zr < -ZW'(PiQ13))     ang_o = -PiQ13;
    else                           ang_o = zr[15:0];
  end

endmodule

// File: src/rotation_matrix_to_euler_angles_core.sv
// Pipeline: 34 register stages from the accepting edge to a valid result: 17
// for the square root, then 17 for the pitch CORDIC.
// Throughput: one transaction per cycle; a stall freezes the whole pipeline.
// Reset: rst_ni clears all valid bits asynchronously; data needs no reset.
// The roll and yaw CORDICs run in parallel with the square root.
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_core
// Converts rotation matrix entries to roll and yaw in Q3.13 radians and pitch in Q2.13 radians.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rotation_matrix_to_euler_angles_core_defines.svh"

module rotation_matrix_to_euler_angles_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] row0_col0_i,
  input  logic signed [15:0] row0_col1_i,
  input  logic signed [15:0] row0_col2_i,
  input  logic signed [15:0] row1_col0_i,
  input  logic signed [15:0] row1_col2_i,
  input  logic signed [15:0] row2_col0_i,
  input  logic signed [15:0] row2_col2_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o
);
  import rme_pkg::*;

  localparam int unsigned Depth = 2 * CordicSteps + 2;

  logic en;
  logic [Depth-1:0] vld_q;
  side_t side_q [Depth];
  side_t side_d;

  logic signed [15:0] r00, r01, r02, r10, r12, r20, r22;
  logic signed [15:0] ry_roll, rx_roll, ry_yaw, rx_yaw;
  logic signed [15:0] roll_a, yaw_a, pitch_a;
  logic signed [15:0] c_in;

  sqrt_t sq_q [CordicSteps+1];
  logic signed [15:0] s_q [CordicSteps+1];
  logic signed [15:0] roll_dl_q [CordicSteps+1];
  logic signed [15:0] yaw_dl_q [CordicSteps+1];

  function automatic logic signed [15:0] clamp16(input logic signed [15:0] v);
    if (v > OneQ14) return OneQ14;
    if (v < -OneQ14) return -OneQ14;
    return v;
  endfunction

  // Whole pipeline advances when the output slot is free or being drained.
  assign en         = !vld_q[Depth-1] || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    r00 = clamp16(row0_col0_i);
    r01 = clamp16(row0_col1_i);
    r02 = clamp16(row0_col2_i);
    r10 = clamp16(row1_col0_i);
    r12 = clamp16(row1_col2_i);
    r20 = clamp16(row2_col0_i);
    r22 = clamp16(row2_col2_i);
    side_d.lock_pos = (r02 == OneQ14);
    side_d.lock_neg = (r02 == -OneQ14);
    ry_yaw = -r01;
    rx_yaw = r00;
    if (side_d.lock_pos) begin
      ry_roll = r10;
      rx_roll = -r20;
    end else if (side_d.lock_neg) begin
      ry_roll = r10;
      rx_roll = r20;
    end else begin
      ry_roll = -r12;
      rx_roll = r22;
    end
  end

  // Valid bits and lock flags travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k < Depth; k++) side_q[k] <= side_q[k-1];
    end
  end

  // Roll and yaw arctangents start at once.
  rme_cordic u_roll (.clk_i, .en_i(en), .y_i(ry_roll), .x_i(rx_roll), .ang_o(roll_a));
  rme_cordic u_yaw  (.clk_i, .en_i(en), .y_i(ry_yaw),  .x_i(rx_yaw),  .ang_o(yaw_a));

  // Square root of 2^28 - s^2, one result bit per stage.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0].rem <= SW'(32'sd268435456 - 32'(r02) * 32'(r02));
      sq_q[0].res <= '0;
      s_q[0]      <= r02;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_sqrt
    localparam logic [SW-1:0] Bit = SW'(1) << (2 * (CordicSteps - 1 - i));
    sqrt_t nx;
    always_comb begin
      if (sq_q[i].rem >= sq_q[i].res + Bit) begin
        nx.rem = sq_q[i].rem - (sq_q[i].res + Bit);
        nx.res = (sq_q[i].res >> 1) + Bit;
      end else begin
        nx.rem = sq_q[i].rem;
        nx.res = sq_q[i].res >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[i+1] <= nx;
        s_q[i+1]  <= s_q[i];
      end
    end
  end

  assign c_in = 16'(sq_q[CordicSteps].res);

  rme_cordic u_pitch (.clk_i, .en_i(en), .y_i(s_q[CordicSteps]), .x_i(c_in), .ang_o(pitch_a));

  // Delay roll and yaw to line up with pitch.
  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_dl_q[0] <= roll_a;
      yaw_dl_q[0]  <= yaw_a;
      for (int k = 1; k < CordicSteps + 1; k++) begin
        roll_dl_q[k] <= roll_dl_q[k-1];
        yaw_dl_q[k]  <= yaw_dl_q[k-1];
      end
    end
  end

  // Select the final angles.
  always_comb begin
    out_valid_o = vld_q[Depth-1];
    if (side_q[Depth-1].lock_pos) begin
      pitch_angle_o = 15'(HalfPiQ13);
      yaw_angle_o   = '0;
      roll_angle_o  = roll_dl_q[CordicSteps];
    end else if (side_q[Depth-1].lock_neg) begin
      pitch_angle_o = -15'(HalfPiQ13);
      yaw_angle_o   = '0;
      roll_angle_o  = -roll_dl_q[CordicSteps];
    end else begin
      if (pitch_a > HalfPiQ13)       pitch_angle_o = 15'(HalfPiQ13);
      else if (pitch_a < -HalfPiQ13) pitch_angle_o = -15'(HalfPiQ13);
      else                           pitch_angle_o = pitch_a[14:0];
      yaw_angle_o  = yaw_dl_q[CordicSteps];
      roll_angle_o = roll_dl_q[CordicSteps];
    end
  end

  // Checks on pipeline control and lock decoding.
  `RME_ASSERT_IMP(a_stall_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o)
  `RME_ASSERT_IMP(a_lock_excl, clk_i, rst_ni, out_valid_o,
    !(side_q[Depth-1].lock_pos && side_q[Depth-1].lock_neg))
  `RME_ASSERT_NXT(a_out_stays, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

endmodule

// File: tb/sv/rotation_matrix_to_euler_angles_core_tb.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_core_tb
// Drives rotation matrix entries into the core, computes the expected roll,
// pitch and yaw with a fixed point CORDIC of its own and checks every result
// transaction in order, under random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotation_matrix_to_euler_angles_core_tb;

  localparam int unsigned NumRandom = 1150;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles = 40;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r22;
  } matrix_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic out_valid_o;
  logic out_ready_i;
  matrix_t mat_q;
  logic signed [15:0] roll_angle_o;
  logic signed [14:0] pitch_angle_o;
  logic signed [15:0] yaw_angle_o;

  matrix_t pending_matrices[$];
  angles_t expected_angles[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit stimulus_done;
  bit hold_sender;

  rotation_matrix_to_euler_angles_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .row0_col0_i  (mat_q.r00),
    .row0_col1_i  (mat_q.r01),
    .row0_col2_i  (mat_q.r02),
    .row1_col0_i  (mat_q.r10),
    .row1_col2_i  (mat_q.r12),
    .row2_col0_i  (mat_q.r20),
    .row2_col2_i  (mat_q.r22),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .roll_angle_o (roll_angle_o),
    .pitch_angle_o(pitch_angle_o),
    .yaw_angle_o  (yaw_angle_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Entries beyond plus or minus one are clamped before use.
  function automatic longint clamp_entry(logic signed [15:0] v);
    longint s;
    s = v;
    if (s > 16384) s = 16384;
    if (s < -16384) s = -16384;
    return s;
  endfunction

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint limit(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint rem, res, b;
    rem = n;
    res = 0;
    b = longint'(1) << 30;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC arctangent of two Q1.14 values, result in Q3.13.
  function automatic longint cordic_atan2(longint y, longint x);
    longint angle_step[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                               256, 128, 64, 32, 16, 8, 4, 2};
    longint vx, vy, acc, t, dx, dy;
    if (x == 0 && y == 0) return 0;
    vx = x * 256;
    vy = y * 256;
    acc = 0;
    if (vx < 0) begin
      t = vx;
      if (vy >= 0) begin
        vx = vy; vy = -t; acc = 102944;
      end else begin
        vx = -vy; vy = t; acc = -102944;
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shift(vy, i);
      dy = floor_shift(vx, i);
      if (vy >= 0) begin
        vx += dx; vy -= dy; acc += angle_step[i];
      end else begin
        vx -= dx; vy += dy; acc -= angle_step[i];
      end
    end
    return limit(floor_shift(acc + 4, 3), 25736);
  endfunction

  function automatic angles_t euler_from_matrix(matrix_t m);
    longint r00, r01, r02, r10, r12, r20, r22, roll, pitch, yaw, c;
    angles_t a;
    r00 = clamp_entry(m.r00); r01 = clamp_entry(m.r01); r02 = clamp_entry(m.r02);
    r10 = clamp_entry(m.r10); r12 = clamp_entry(m.r12);
    r20 = clamp_entry(m.r20); r22 = clamp_entry(m.r22);
    if (r02 == 16384) begin
      pitch = 12868; yaw = 0;
      roll = cordic_atan2(r10, -r20);
    end else if (r02 == -16384) begin
      pitch = -12868; yaw = 0;
      roll = -cordic_atan2(r10, r20);
    end else begin
      c = int_sqrt(16384 * 16384 - r02 * r02);
      pitch = limit(cordic_atan2(r02, c), 12868);
      yaw = cordic_atan2(-r01, r00);
      roll = cordic_atan2(-r12, r22);
    end
    a.roll = 16'(limit(roll, 25736));
    a.pitch = 15'(pitch);
    a.yaw = 16'(limit(yaw, 25736));
    return a;
  endfunction

  // Mostly in-range entries, sometimes any 16-bit pattern.
  function automatic logic signed [15:0] rand_entry();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'sd16384;
      2: return -16'sd16384;
      3: return 16'sd0;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    m.r00 = rand_entry(); m.r01 = rand_entry(); m.r02 = rand_entry();
    m.r10 = rand_entry(); m.r12 = rand_entry(); m.r20 = rand_entry();
    m.r22 = rand_entry();
    // Gimbal lock on either side now and then.
    if ($urandom_range(0, 9) == 0) m.r02 = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    return m;
  endfunction

  // Stimulus: directed cases first, then random matrices.
  initial begin
    matrix_t m;
    logic signed [15:0] edge_vals[6] = '{16'sd16384, -16'sd16384, 16'sd0,
                                        16'sh7fff, 16'sh8000, 16'sd1};
    m = '0; m.r00 = 16'sd16384; m.r22 = 16'sd16384;
    pending_matrices.push_back(m);                       // identity
    m = '0; pending_matrices.push_back(m);               // both arguments zero
    m = '0; m.r00 = -16'sd16384; m.r22 = -16'sd16384;
    pending_matrices.push_back(m);                       // zero y, negative x
    for (int i = 0; i < 6; i++) begin
      m = '0;
      m.r00 = edge_vals[i]; m.r01 = edge_vals[5 - i]; m.r02 = edge_vals[(i + 2) % 6];
      m.r10 = edge_vals[(i + 3) % 6]; m.r12 = edge_vals[(i + 4) % 6];
      m.r20 = edge_vals[i]; m.r22 = edge_vals[(i + 1) % 6];
      pending_matrices.push_back(m);
    end
    for (int i = 0; i < 4; i++) begin
      m = rand_matrix(); m.r02 = (i % 2) ? -16'sd16384 : 16'sd16384;
      if (i >= 2) m.r02 = (i % 2) ? 16'sh8000 : 16'sh7fff;  // clamped into lock
      pending_matrices.push_back(m);
    end
    m = rand_matrix(); m.r02 = 16'sd16383; pending_matrices.push_back(m);
    m = rand_matrix(); m.r02 = -16'sd16383; pending_matrices.push_back(m);
    for (int i = 0; i < NumRandom; i++) pending_matrices.push_back(rand_matrix());
  end

  // Driver: one transaction at a time with a random gap before each.
  int unsigned send_gap;
  int unsigned sent_count;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mat_q <= '0;
      send_gap <= 0;
      sent_count <= 0;
      hold_sender <= 1'b0;
      stimulus_done <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        expected_angles.push_back(euler_from_matrix(mat_q));
        sent_count <= sent_count + 1;
      end
      if (in_valid_i && sent_count == 300) begin
        // Pause until the pipeline has fully drained once.
        hold_sender <= 1'b1;
        in_valid_i <= 1'b0;
      end else if (hold_sender) begin
        if (expected_angles.size() == 0) hold_sender <= 1'b0;
        in_valid_i <= 1'b0;
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_matrices.size() != 0) begin
        mat_q <= pending_matrices.pop_front();
        in_valid_i <= 1'b1;
        send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
      end else begin
        in_valid_i <= 1'b0;
        stimulus_done <= 1'b1;
      end
    end
  end

  // Monitor: random back pressure and in-order comparison.
  int unsigned stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    angles_t exp_a;
    int unsigned gap;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
      mismatch_count <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_angles.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected result transaction");
        end else begin
          exp_a = expected_angles.pop_front();
          if (roll_angle_o !== exp_a.roll || pitch_angle_o !== exp_a.pitch ||
              yaw_angle_o !== exp_a.yaw) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (exp/act)",
                       exp_a.roll, roll_angle_o, exp_a.pitch, pitch_angle_o,
                       exp_a.yaw, yaw_angle_o);
          end
        end
        // A zero draw keeps ready high so results can follow back to back.
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8) : 0;
        stall_left <= gap;
        out_ready_i <= (gap == 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Reset, then wait for the drain or the watchdog.
  initial begin
    rst_ni = 1'b0;
    idle_cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(stimulus_done && expected_angles.size() == 0)) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) break;
    end
    if (idle_cycles < WatchdogLimit) repeat (DrainCycles) @(posedge clk_i);
    if (idle_cycles < WatchdogLimit && mismatch_count == 0 && expected_angles.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/rme_pkg.sv
src/rme_cordic.sv
src/rotation_matrix_to_euler_angles_core.sv
tb/sv/rotation_matrix_to_euler_angles_core_tb.sv
